### hw/rtl/gn_pkg.sv
package gn_pkg;

  // Fixed field widths of the block.
  localparam int TABLE_SIZE    = 256;
  localparam int CELL_W        = 8;
  localparam int COORD_W       = 32;
  localparam int SCALE_W       = 24;
  localparam int OUT_W         = 18;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MQ_DEPTH      = 4;
  localparam int OQ_DEPTH      = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;
  localparam logic signed [31:0] OUT_MAX     = 32'sd131071;
  localparam logic signed [31:0] OUT_MIN     = -32'sd131072;

  // Request kinds.
  localparam logic MODE_EVAL = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  // Width of one request as it travels from the front part to the back part.
  function automatic int item_width(input int frac_bits);
    return 1 + 3 * CELL_W + 3 * frac_bits + 2 * CELL_W;
  endfunction

  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
    logic signed [1:0] gz;
  } grad_t;

  // The fixed set of sixteen corner gradients.
  function automatic grad_t grad_of(input logic [3:0] h);
    grad_t g;
    case (h)
      4'd0:    g = '{2'sd1,  2'sd1,  2'sd0};
      4'd1:    g = '{-2'sd1, 2'sd1,  2'sd0};
      4'd2:    g = '{2'sd1,  -2'sd1, 2'sd0};
      4'd3:    g = '{-2'sd1, -2'sd1, 2'sd0};
      4'd4:    g = '{2'sd1,  2'sd0,  2'sd1};
      4'd5:    g = '{-2'sd1, 2'sd0,  2'sd1};
      4'd6:    g = '{2'sd1,  2'sd0,  -2'sd1};
      4'd7:    g = '{-2'sd1, 2'sd0,  -2'sd1};
      4'd8:    g = '{2'sd0,  2'sd1,  2'sd1};
      4'd9:    g = '{2'sd0,  -2'sd1, 2'sd1};
      4'd10:   g = '{2'sd0,  2'sd1,  -2'sd1};
      4'd11:   g = '{2'sd0,  -2'sd1, -2'sd1};
      4'd12:   g = '{2'sd1,  2'sd1,  2'sd0};
      4'd13:   g = '{-2'sd1, 2'sd1,  2'sd0};
      4'd14:   g = '{2'sd0,  -2'sd1, 2'sd1};
      4'd15:   g = '{2'sd0,  -2'sd1, -2'sd1};
      default: g = '{2'sd0,  2'sd0,  2'sd0};
    endcase
    return g;
  endfunction

endpackage

### hw/rtl/gn_fifo.sv
module gn_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Pointer and fill count updates; the producer never pushes when full.
  always_comb begin
    wptr_nxt  = push ? wptr_r + AW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + AW'(1) : rptr_r;
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

### hw/rtl/gn_perm_ram.sv
module gn_perm_ram
  import gn_pkg::*;
#(
  parameter int DEPTH = gn_pkg::TABLE_SIZE
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [gn_pkg::CELL_W-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr0,
  input  logic [$clog2(DEPTH)-1:0]  raddr1,
  output logic [gn_pkg::CELL_W-1:0] rdata0,
  output logic [gn_pkg::CELL_W-1:0] rdata1
);

  logic [CELL_W-1:0] mem_r [DEPTH];
  logic [CELL_W-1:0] rd0_r, rd1_r;

  // One write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd0_r <= mem_r[raddr0];
    rd1_r <= mem_r[raddr1];
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

### hw/rtl/gn_front.sv
module gn_front
  import gn_pkg::*;
#(
  parameter int FRAC_BITS = gn_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gn_pkg::SCALE_W-1:0]        cfg_wr_data,
  input  logic                              accept,
  input  logic                              mode,
  input  logic signed [gn_pkg::COORD_W-1:0] coord_x,
  input  logic signed [gn_pkg::COORD_W-1:0] coord_y,
  input  logic signed [gn_pkg::COORD_W-1:0] coord_z,
  input  logic [gn_pkg::CELL_W-1:0]         table_index,
  input  logic [gn_pkg::CELL_W-1:0]         table_value,
  output logic                              item_valid,
  output logic [gn_pkg::item_width(FRAC_BITS)-1:0] item
);

  localparam int PW = COORD_W + SCALE_W + 1;

  logic [SCALE_W-1:0]   scale_r;
  logic                 valid_r;
  logic                 mode_r;
  logic [CELL_W-1:0]    cell_r [3];
  logic [FRAC_BITS-1:0] frac_r [3];
  logic [CELL_W-1:0]    idx_r, val_r;
  logic signed [PW-1:0] prod [3];

  // Scale each coordinate; the product is exact.
  always_comb begin
    prod[0] = $signed(coord_x) * $signed({1'b0, scale_r});
    prod[1] = $signed(coord_y) * $signed({1'b0, scale_r});
    prod[2] = $signed(coord_z) * $signed({1'b0, scale_r});
  end

  // Configuration register and request valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
      valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      valid_r <= accept;
    end
  end

  // Split each scaled coordinate into its lattice cell and its fraction.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode;
      idx_r  <= table_index;
      val_r  <= table_value;
      for (int a = 0; a < 3; a++) begin
        cell_r[a] <= prod[a][2*FRAC_BITS+CELL_W-1:2*FRAC_BITS];
        frac_r[a] <= prod[a][2*FRAC_BITS-1:FRAC_BITS];
      end
    end
  end

  assign item_valid = valid_r;
  assign item = {mode_r, cell_r[0], cell_r[1], cell_r[2],
                 frac_r[0], frac_r[1], frac_r[2], idx_r, val_r};

endmodule

### hw/rtl/gn_back.sv
module gn_back
  import gn_pkg::*;
#(
  parameter int FRAC_BITS = gn_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [gn_pkg::item_width(FRAC_BITS)-1:0] head,
  input  logic                                     head_empty,
  output logic                                     head_pop,
  input  logic                                     out_pop,
  output logic                                     out_empty,
  output logic signed [gn_pkg::OUT_W-1:0]          out_value
);

  localparam int F  = FRAC_BITS;
  localparam int MW = F + 6;
  localparam int VW = F + 4;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(OQ_DEPTH) + 1;
  localparam logic signed [MW-1:0] ONE_M = MW'(1 << F);
  localparam logic signed [VW-1:0] ONE_V = VW'(1 << F);

  function automatic logic signed [MW-1:0] mulq(input logic signed [MW-1:0] a,
                                                input logic signed [MW-1:0] b);
    logic signed [2*MW-1:0] p;
    p = a * b;
    return MW'(p >>> F);
  endfunction

  function automatic logic signed [VW-1:0] mulw(input logic signed [MW-1:0] w,
                                                input logic signed [VW:0]   d);
    logic signed [MW+VW:0] p;
    p = w * d;
    return VW'(p >>> F);
  endfunction

  function automatic logic signed [VW-1:0] gterm(input logic signed [1:0]    g,
                                                 input logic signed [VW-1:0] d);
    logic signed [VW-1:0] r;
    case (g)
      2'sb01:  r = d;
      2'sb11:  r = -d;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Head of the request queue.
  logic              h_mode;
  logic [CELL_W-1:0] h_cx, h_cy, h_cz, h_idx, h_val;
  logic [F-1:0]      h_fx, h_fy, h_fz;
  assign {h_mode, h_cx, h_cy, h_cz, h_fx, h_fy, h_fz, h_idx, h_val} = head;

  // Result credits: every evaluate in flight owns a slot in the output queue.
  logic [CW-1:0] oq_count;
  logic [CW-1:0] infl_r, infl_nxt;
  logic          credit_ok, ev_issue, ld_issue, res_push;

  assign credit_ok = ({1'b0, oq_count} + {1'b0, infl_r}) < (CW+1)'(OQ_DEPTH);
  assign head_pop  = !head_empty && ((h_mode == MODE_LOAD) || credit_ok);
  assign ev_issue  = head_pop && (h_mode == MODE_EVAL);
  assign ld_issue  = head_pop && (h_mode == MODE_LOAD);
  assign infl_nxt  = infl_r + CW'(ev_issue) - CW'(res_push);

  // Pipeline registers.
  logic                 v0_r, ld0_r, v1_r, ld1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [CELL_W-1:0]    cell0_r [3];
  logic [F-1:0]         frac0_r [3], frac1_r [3], frac2_r [3];
  logic [CELL_W-1:0]    idx0_r, val0_r, idx1_r, val1_r, cx1_r;
  logic signed [MW-1:0] ta1_r [3], tt1_r [3], c2_r [3], t3_2_r [3], w3_r [3];
  logic signed [VW-1:0] d3_r [8];
  logic signed [VW-1:0] la4_r [4], lp4_r [4], x5_r [4];
  logic signed [VW-1:0] la6_r [2], lp6_r [2], y7_r [2];
  logic signed [VW-1:0] la8_r, lp8_r;
  logic signed [MW-1:0] wy4_r, wz4_r, wy5_r, wz5_r, wz6_r, wz7_r;

  // Permutation table copies, one level of the hash each.
  logic [CELL_W-1:0] h1 [2];
  logic [CELL_W-1:0] h2 [4];
  logic [CELL_W-1:0] h3 [8];

  // First level: written as a load leaves the queue.
  gn_perm_ram #(.DEPTH(TABLE_SIZE)) u_l1 (
    .clk    (clk),
    .we     (ld_issue),
    .waddr  (AW'(h_idx)),
    .wdata  (h_val),
    .raddr0 (AW'(h_cz)),
    .raddr1 (AW'(h_cz + CELL_W'(1))),
    .rdata0 (h1[0]),
    .rdata1 (h1[1])
  );

  // Second level: one copy per z corner, written as a load passes stage 0.
  for (genvar k = 0; k < 2; k++) begin : g_l2
    gn_perm_ram #(.DEPTH(TABLE_SIZE)) u_l2 (
      .clk    (clk),
      .we     (ld0_r),
      .waddr  (AW'(idx0_r)),
      .wdata  (val0_r),
      .raddr0 (AW'(cell0_r[1] + h1[k])),
      .raddr1 (AW'(cell0_r[1] + CELL_W'(1) + h1[k])),
      .rdata0 (h2[2*k]),
      .rdata1 (h2[2*k+1])
    );
  end

  // Third level: one copy per y-z corner pair, written as a load passes stage 1.
  for (genvar j = 0; j < 4; j++) begin : g_l3
    gn_perm_ram #(.DEPTH(TABLE_SIZE)) u_l3 (
      .clk    (clk),
      .we     (ld1_r),
      .waddr  (AW'(idx1_r)),
      .wdata  (val1_r),
      .raddr0 (AW'(cx1_r + h2[j])),
      .raddr1 (AW'(cx1_r + CELL_W'(1) + h2[j])),
      .rdata0 (h3[2*j]),
      .rdata1 (h3[2*j+1])
    );
  end

  // Fade curve, first step: t*(6t - 15) and t*t.
  logic signed [MW-1:0] t0 [3], fa0 [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      t0[a]  = MW'({1'b0, frac0_r[a]});
      fa0[a] = MW'(6) * t0[a] - MW'(15) * ONE_M;
    end
  end

  // Corner dot products from the hashed gradients.
  logic signed [VW-1:0] dot2 [8];
  always_comb begin
    logic signed [VW-1:0] dx, dy, dz;
    grad_t g;
    for (int c = 0; c < 8; c++) begin
      dx = VW'({1'b0, frac2_r[0]}) - (c[0] ? ONE_V : '0);
      dy = VW'({1'b0, frac2_r[1]}) - (c[1] ? ONE_V : '0);
      dz = VW'({1'b0, frac2_r[2]}) - (c[2] ? ONE_V : '0);
      g  = grad_of(h3[c][3:0]);
      dot2[c] = gterm(g.gx, dx) + gterm(g.gy, dy) + gterm(g.gz, dz);
    end
  end

  // Valid bits and credit count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= '0;
      v0_r   <= 1'b0;
      ld0_r  <= 1'b0;
      v1_r   <= 1'b0;
      ld1_r  <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      v6_r   <= 1'b0;
      v7_r   <= 1'b0;
      v8_r   <= 1'b0;
    end else begin
      infl_r <= infl_nxt;
      v0_r   <= ev_issue;
      ld0_r  <= ld_issue;
      v1_r   <= v0_r;
      ld1_r  <= ld0_r;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      v4_r   <= v3_r;
      v5_r   <= v4_r;
      v6_r   <= v5_r;
      v7_r   <= v6_r;
      v8_r   <= v7_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Stage 0: popped request.
    cell0_r <= '{h_cx, h_cy, h_cz};
    frac0_r <= '{h_fx, h_fy, h_fz};
    idx0_r  <= h_idx;
    val0_r  <= h_val;
    // Stage 1: first fade products.
    cx1_r   <= cell0_r[0];
    idx1_r  <= idx0_r;
    val1_r  <= val0_r;
    frac1_r <= frac0_r;
    for (int a = 0; a < 3; a++) begin
      ta1_r[a] <= mulq(t0[a], fa0[a]);
      tt1_r[a] <= mulq(t0[a], t0[a]);
    end
    // Stage 2: t*(... + 10) and t cubed.
    frac2_r <= frac1_r;
    for (int a = 0; a < 3; a++) begin
      c2_r[a]   <= mulq(MW'({1'b0, frac1_r[a]}), ta1_r[a] + MW'(10) * ONE_M);
      t3_2_r[a] <= mulq(tt1_r[a], MW'({1'b0, frac1_r[a]}));
    end
    // Stage 3: weights and dot products.
    for (int a = 0; a < 3; a++) begin
      w3_r[a] <= mulq(t3_2_r[a], c2_r[a]);
    end
    d3_r <= dot2;
    // Stages 4 and 5: blend along x.
    for (int j = 0; j < 4; j++) begin
      la4_r[j] <= d3_r[2*j];
      lp4_r[j] <= mulw(w3_r[0], (VW+1)'(d3_r[2*j+1]) - (VW+1)'(d3_r[2*j]));
      x5_r[j]  <= la4_r[j] + lp4_r[j];
    end
    wy4_r <= w3_r[1];
    wz4_r <= w3_r[2];
    wy5_r <= wy4_r;
    wz5_r <= wz4_r;
    // Stages 6 and 7: blend along y.
    for (int k = 0; k < 2; k++) begin
      la6_r[k] <= x5_r[2*k];
      lp6_r[k] <= mulw(wy5_r, (VW+1)'(x5_r[2*k+1]) - (VW+1)'(x5_r[2*k]));
      y7_r[k]  <= la6_r[k] + lp6_r[k];
    end
    wz6_r <= wz5_r;
    wz7_r <= wz6_r;
    // Stage 8: blend along z.
    la8_r <= y7_r[0];
    lp8_r <= mulw(wz7_r, (VW+1)'(y7_r[1]) - (VW+1)'(y7_r[0]));
  end

  // Final sum and saturation.
  logic signed [VW-1:0] res;
  logic signed [31:0]   res32;
  logic signed [OUT_W-1:0] res_sat;
  always_comb begin
    res   = la8_r + lp8_r;
    res32 = 32'(res);
    if (res32 > OUT_MAX) begin
      res_sat = OUT_W'(OUT_MAX);
    end else if (res32 < OUT_MIN) begin
      res_sat = OUT_W'(OUT_MIN);
    end else begin
      res_sat = OUT_W'(res32);
    end
  end

  assign res_push = v8_r;

  // Output queue.
  gn_fifo #(.W(OUT_W), .DEPTH(OQ_DEPTH)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_sat),
    .pop   (out_pop && !out_empty),
    .rdata (out_value),
    .empty (out_empty),
    .count (oq_count)
  );

endmodule

### hw/rtl/gradient_noise_3d.sv
// 3D improved gradient noise, one point per request. Push evaluate requests
// (mode 0) with Q16.16 coordinates, or load requests (mode 1) that write one
// permutation table entry; only evaluate requests produce a result, in order.
// The table has no reset value and must be loaded before any entry is used.
// The block takes one request per clock cycle while in_full is low, loads included,
// and returns one result per cycle while results are popped. An evaluate
// request passes coordinate scaling in the front register, the request queue,
// three dependent permutation table reads through replicated table copies,
// and the multiplier stages of the fade curve and trilinear blend. Results
// wait in a 32-entry output queue; once it fills, requests back up and full rises.
// coord_scale should only be written while no request is in flight.
module gradient_noise_3d
  import gn_pkg::*;
#(
  parameter int FRAC_BITS = gn_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [gn_pkg::SCALE_W-1:0]        cfg_wr_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_mode,
  input  logic signed [gn_pkg::COORD_W-1:0] in_coord_x,
  input  logic signed [gn_pkg::COORD_W-1:0] in_coord_y,
  input  logic signed [gn_pkg::COORD_W-1:0] in_coord_z,
  input  logic [gn_pkg::CELL_W-1:0]         in_table_index,
  input  logic [gn_pkg::CELL_W-1:0]         in_table_value,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [gn_pkg::OUT_W-1:0]   out_noise_value
);

  localparam int IW  = item_width(FRAC_BITS);
  localparam int MCW = $clog2(MQ_DEPTH) + 1;

  logic          accept;
  logic          f_valid;
  logic [IW-1:0] f_item;
  logic [IW-1:0] mq_head;
  logic          mq_empty, mq_pop;
  logic [MCW-1:0] mq_count;

  // The front stage and the request queue together never hold more than the queue.
  assign in_full = ({1'b0, mq_count} + (MCW+1)'(f_valid)) >= (MCW+1)'(MQ_DEPTH);
  assign accept  = in_push && !in_full;

  gn_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .mode        (in_mode),
    .coord_x     (in_coord_x),
    .coord_y     (in_coord_y),
    .coord_z     (in_coord_z),
    .table_index (in_table_index),
    .table_value (in_table_value),
    .item_valid  (f_valid),
    .item        (f_item)
  );

  gn_fifo #(.W(IW), .DEPTH(MQ_DEPTH)) u_mq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_valid),
    .wdata (f_item),
    .pop   (mq_pop),
    .rdata (mq_head),
    .empty (mq_empty),
    .count (mq_count)
  );

  gn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (mq_head),
    .head_empty (mq_empty),
    .head_pop   (mq_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_value  (out_noise_value)
  );

endmodule

### hw/rtl/gn_checker.sv
module gn_checker
  import gn_pkg::*;
(
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_push,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic signed [gn_pkg::OUT_W-1:0] out_noise_value
);

  // Out of reset, nothing is waiting and requests are taken.
  a_reset_state: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // Full only rises right after a request was accepted.
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("full rose without an accepted request");

  // A result that is not taken stays available.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result vanished");

  // A waiting result holds its value.
  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_noise_value))
    else $error("waiting result changed");

endmodule

bind gradient_noise_3d gn_checker u_gn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_push         (in_push),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_noise_value (out_noise_value)
);
